>>> src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands for the record list; compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define PRL_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle check");

// next-cycle implication
`define PRL_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle check");

`else

`define PRL_ASSERT_NOW(lbl, clk, rst, ante, cons)
`define PRL_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

>>> src/prl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prl_pkg
// Shared types, constants and helpers of the positional record list.
// ----------------------------------------------------------------------------
package prl_pkg;

   localparam int unsigned PRL_CAPACITY = 64;
   localparam int unsigned NAME_BUF     = 20;
   localparam int unsigned NAME_CHARS   = NAME_BUF - 1;
   localparam int unsigned NAME_W       = 8 * NAME_CHARS;
   localparam int unsigned CARD_W       = 32;
   localparam int unsigned POS_W        = 8;
   localparam int unsigned CMD_W        = 3;

   typedef logic [NAME_W-1:0] name_type;

   typedef enum logic [CMD_W-1:0] {
      CMD_INSERT = 3'd0,
      CMD_DELETE = 3'd1,
      CMD_READ   = 3'd2,
      CMD_SEARCH = 3'd3,
      CMD_SERVE  = 3'd4
   } cmd_type;

   typedef struct packed {
      logic [CARD_W-1:0] card;
      name_type          name;
   } rec_type;

   localparam int unsigned REC_W = $bits(rec_type);

   typedef struct packed {
      logic [CMD_W-1:0]  command;
      logic [POS_W-1:0]  position;
      logic [CARD_W-1:0] card;
      name_type          name;
   } req_type;

   typedef struct packed {
      logic              ok;
      logic [POS_W-1:0]  position;
      rec_type           rec;
      logic [POS_W-1:0]  count;
   } rsp_type;

   function automatic int unsigned addr_w(input int unsigned n);
      return (n > 1) ? $clog2(n) : 1;
   endfunction

   // Clear every byte after the first zero byte of the name.
   function automatic name_type norm_name(input name_type raw);
      name_type res;
      logic     alive;
      res   = '0;
      alive = 1'b1;
      for (int k = 0; k < NAME_CHARS; k++) begin
         if (alive) begin
            res[8*k +: 8] = raw[8*k +: 8];
         end
         if (raw[8*k +: 8] == 8'd0) begin
            alive = 1'b0;
         end
      end
      return res;
   endfunction

endpackage

>>> src/prl_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prl_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module prl_ram
   import prl_pkg::*;
#(
   parameter int unsigned WIDTH = REC_W,
   parameter int unsigned DEPTH = PRL_CAPACITY
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [addr_w(DEPTH)-1:0]   wr_addr,
   input  logic [WIDTH-1:0]           wr_data,
   input  logic                       rd_en,
   input  logic [addr_w(DEPTH)-1:0]   rd_addr,
   output logic [WIDTH-1:0]           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/prl_engine.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// prl_engine
// Sequencer around one RAM move/compare loop: shifts records for insert and
// delete, walks the list for search, fetches a record for read.
// ----------------------------------------------------------------------------
module prl_engine
   import prl_pkg::*;
#(
   parameter int unsigned CAPACITY = PRL_CAPACITY
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  req_type req,
   output logic    ready,
   output logic    done_valid,
   input  logic    done_take,
   output rsp_type done_rsp
);

   localparam int unsigned AddrW = addr_w(CAPACITY);
   localparam int unsigned CntW  = $clog2(CAPACITY + 1);

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_SHIFT = 5'b00010,
      ST_WRITE = 5'b00100,
      ST_SCAN  = 5'b01000,
      ST_DONE  = 5'b10000
   } state_type;

   state_type         state_ff, state_in;
   logic [CntW-1:0]   count_ff, count_in;
   logic [AddrW-1:0]  src_ff, src_in;
   logic [AddrW-1:0]  end_ff, end_in;
   logic [AddrW-1:0]  wr_addr_ff, wr_addr_in;
   logic [AddrW-1:0]  idx_ff, idx_in;
   logic              moving_ff, moving_in;
   logic              pend_ff, pend_in;
   logic              grow_ff, grow_in;
   logic              force_ff, force_in;
   rec_type           rec_ff, rec_in;
   logic              res_ok_ff, res_ok_in;
   logic [POS_W-1:0]  res_pos_ff, res_pos_in;
   rec_type           res_rec_ff, res_rec_in;

   logic              ram_wr_en;
   logic [AddrW-1:0]  ram_wr_addr;
   rec_type           ram_wr_data;
   logic              ram_rd_en;
   rec_type           ram_rd_data;

   logic [POS_W:0]    pos9;
   logic [POS_W:0]    cnt9;
   logic              ins_ok;
   logic              rng_ok;
   logic [AddrW-1:0]  pos_idx;
   logic [AddrW-1:0]  last_idx;
   logic [AddrW-1:0]  del_idx;
   logic              del_ok;
   logic [AddrW-1:0]  step_src;

   prl_ram #(
      .WIDTH (REC_W),
      .DEPTH (CAPACITY)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (src_ff),
      .rd_data (ram_rd_data)
   );

   assign pos9     = {1'b0, req.position};
   assign cnt9     = (POS_W + 1)'(count_ff);
   assign ins_ok   = (req.position != '0) && (pos9 <= cnt9 + 1'b1)
                     && (cnt9 < (POS_W + 1)'(CAPACITY));
   assign rng_ok   = (req.position != '0) && (pos9 <= cnt9);
   assign pos_idx  = AddrW'(req.position - 1'b1);
   assign last_idx = AddrW'(count_ff - 1'b1);
   assign del_idx  = (req.command == CMD_SERVE) ? '0 : pos_idx;
   assign del_ok   = (req.command == CMD_SERVE) ? (count_ff != '0) : rng_ok;
   assign step_src = grow_ff ? (src_ff - 1'b1) : (src_ff + 1'b1);

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      src_in      = src_ff;
      end_in      = end_ff;
      wr_addr_in  = wr_addr_ff;
      idx_in      = idx_ff;
      moving_in   = moving_ff;
      pend_in     = pend_ff;
      grow_in     = grow_ff;
      force_in    = force_ff;
      rec_in      = rec_ff;
      res_ok_in   = res_ok_ff;
      res_pos_in  = res_pos_ff;
      res_rec_in  = res_rec_ff;
      ram_wr_en   = 1'b0;
      ram_wr_addr = wr_addr_ff;
      ram_wr_data = ram_rd_data;
      ram_rd_en   = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               rec_in     = '{card: req.card, name: norm_name(req.name)};
               res_ok_in  = 1'b0;
               res_pos_in = '0;
               res_rec_in = '0;
               moving_in  = 1'b1;
               pend_in    = 1'b0;
               grow_in    = 1'b0;
               force_in   = 1'b0;
               state_in   = ST_DONE;
               case (req.command)
                  CMD_INSERT: begin
                     if (ins_ok) begin
                        count_in  = count_ff + 1'b1;
                        res_ok_in = 1'b1;
                        idx_in    = pos_idx;
                        if (pos9 == cnt9 + 1'b1) begin
                           state_in = ST_WRITE;
                        end else begin
                           // move the tail back one slot, last record first
                           src_in   = last_idx;
                           end_in   = pos_idx;
                           grow_in  = 1'b1;
                           state_in = ST_SHIFT;
                        end
                     end
                  end
                  CMD_DELETE, CMD_SERVE: begin
                     if (del_ok) begin
                        count_in  = count_ff - 1'b1;
                        res_ok_in = 1'b1;
                        if (del_idx != last_idx) begin
                           src_in   = del_idx + 1'b1;
                           end_in   = last_idx;
                           state_in = ST_SHIFT;
                        end
                     end
                  end
                  CMD_READ: begin
                     if (rng_ok) begin
                        src_in   = pos_idx;
                        end_in   = pos_idx;
                        force_in = 1'b1;
                        state_in = ST_SCAN;
                     end
                  end
                  CMD_SEARCH: begin
                     if (count_ff != '0) begin
                        src_in   = '0;
                        end_in   = last_idx;
                        state_in = ST_SCAN;
                     end
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_SHIFT: begin
            // read one slot ahead, write the record read last cycle into the next slot over
            ram_rd_en  = moving_ff;
            ram_wr_en  = pend_ff;
            pend_in    = moving_ff;
            wr_addr_in = grow_ff ? (src_ff + 1'b1) : (src_ff - 1'b1);
            if (moving_ff) begin
               if (src_ff == end_ff) begin
                  moving_in = 1'b0;
               end else begin
                  src_in = step_src;
               end
            end
            if (!moving_ff && !pend_ff) begin
               state_in = grow_ff ? ST_WRITE : ST_DONE;
            end
         end
         ST_WRITE: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = idx_ff;
            ram_wr_data = rec_ff;
            state_in    = ST_DONE;
         end
         ST_SCAN: begin
            ram_rd_en  = moving_ff;
            pend_in    = moving_ff;
            wr_addr_in = src_ff;
            if (moving_ff) begin
               if (src_ff == end_ff) begin
                  moving_in = 1'b0;
               end else begin
                  src_in = step_src;
               end
            end
            if (pend_ff && (force_ff || (ram_rd_data.name == rec_ff.name))) begin
               res_ok_in  = 1'b1;
               res_pos_in = POS_W'(wr_addr_ff) + 1'b1;
               res_rec_in = ram_rd_data;
               state_in   = ST_DONE;
            end else if (!moving_ff && !pend_ff) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (done_take) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      src_ff     <= src_in;
      end_ff     <= end_in;
      wr_addr_ff <= wr_addr_in;
      idx_ff     <= idx_in;
      moving_ff  <= moving_in;
      pend_ff    <= pend_in;
      grow_ff    <= grow_in;
      force_ff   <= force_in;
      rec_ff     <= rec_in;
      res_ok_ff  <= res_ok_in;
      res_pos_ff <= res_pos_in;
      res_rec_ff <= res_rec_in;
   end

   assign ready      = (state_ff == ST_IDLE);
   assign done_valid = (state_ff == ST_DONE);
   assign done_rsp   = '{ok:       res_ok_ff,
                         position: res_pos_ff,
                         rec:      res_rec_ff,
                         count:    POS_W'(count_ff)};

   `PRL_ASSERT_NOW(a_count_cap, clock, reset, 1'b1, count_ff <= CntW'(CAPACITY))
   `PRL_ASSERT_NOW(a_shift_no_clash, clock, reset, (state_ff == ST_SHIFT) && moving_ff && pend_ff, wr_addr_ff != src_ff)
   `PRL_ASSERT_NEXT(a_count_hold, clock, reset, !((state_ff == ST_IDLE) && start), $stable(count_ff))
   `PRL_ASSERT_NOW(a_hit_in_list, clock, reset, (state_ff == ST_DONE) && (res_pos_ff != '0), res_ok_ff && ((POS_W + 1)'(res_pos_ff) <= (POS_W + 1)'(count_ff)))

endmodule

>>> src/positional_record_list_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_record_list_top
// Ordered record list with insert, delete, read, search and serve commands.
// ----------------------------------------------------------------------------
// One item is taken at a time, and each gives one result item. All work runs
// through a single RAM (one write and one registered read port) under a small
// sequencer that moves or compares one record per cycle. Read fetches the
// record at its position. Insert at p moves the records from p on back by
// one slot, last record first, then writes the new record; an append only
// writes it. Delete at p moves the records after p forward by one slot;
// deleting the last record moves nothing, and serve is delete at 1. Search
// compares the records from the head and stops at the first hit. Failed and
// unknown commands move and compare nothing. The longest items are an insert
// at the head of a list one short of full and a search miss on a full list.
// If the output register is free, the sequencer is idle again at the edge
// that presents the result, and the next item can then be accepted while
// that result still waits in the output register. A stalled result holds the
// sequencer only when the next result is ready behind it. There is no
// clearing pass after reset: the list starts empty.
module positional_record_list_top
   import prl_pkg::*;
#(
   parameter int unsigned CAPACITY = PRL_CAPACITY
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [CMD_W-1:0]         req_command,
   input  logic [POS_W-1:0]         req_position,
   input  logic signed [CARD_W-1:0] req_card_no,
   input  logic [63:0]              req_name_part0,
   input  logic [63:0]              req_name_part1,
   input  logic [23:0]              req_name_part2,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic                     rsp_ok,
   output logic [POS_W-1:0]         rsp_found_position,
   output logic signed [CARD_W-1:0] rsp_record_card,
   output logic [63:0]              rsp_record_name0,
   output logic [63:0]              rsp_record_name1,
   output logic [23:0]              rsp_record_name2,
   output logic [POS_W-1:0]         rsp_entry_count
);

   logic    eng_ready;
   logic    eng_start;
   req_type eng_req;
   logic    eng_done;
   logic    eng_take;
   rsp_type eng_rsp;

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   assign req_stall = !eng_ready;
   assign eng_start = req_valid && eng_ready;
   assign eng_req   = '{command:  req_command,
                        position: req_position,
                        card:     req_card_no,
                        name:     {req_name_part2, req_name_part1, req_name_part0}};

   prl_engine #(
      .CAPACITY (CAPACITY)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .start      (eng_start),
      .req        (eng_req),
      .ready      (eng_ready),
      .done_valid (eng_done),
      .done_take  (eng_take),
      .done_rsp   (eng_rsp)
   );

   // output register frees up when empty or being taken this cycle
   assign eng_take = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (eng_take) begin
         rsp_valid_in = eng_done;
         if (eng_done) begin
            rsp_in = eng_rsp;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_ok             = rsp_ff.ok;
   assign rsp_found_position = rsp_ff.position;
   assign rsp_record_card    = rsp_ff.rec.card;
   assign rsp_record_name0   = rsp_ff.rec.name[63:0];
   assign rsp_record_name1   = rsp_ff.rec.name[127:64];
   assign rsp_record_name2   = rsp_ff.rec.name[151:128];
   assign rsp_entry_count    = rsp_ff.count;

endmodule

>>> tb/sv/positional_record_list_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_record_list_top_tb
// Self-checking bench for the ordered record list. A queue-based shadow list
// predicts every result (insert, delete, read, search, serve, unused codes).
// A directed pass covers empty-list, boundary-position and name-termination
// cases. Random traffic then fills and drains the list under several
// sender-gap and receiver-stall mixes.
// ----------------------------------------------------------------------------
module positional_record_list_top_tb;
   import prl_pkg::*;

   localparam int unsigned LIST_DEPTH  = PRL_CAPACITY;
   localparam int unsigned POOL_SIZE   = 12;
   localparam int unsigned TAIL_CYCLES = LIST_DEPTH + 16;
   localparam logic [CMD_W-1:0] CMD_UNUSED_FIRST = 3'd5;
   localparam logic [CMD_W-1:0] CMD_UNUSED_LAST  = 3'd7;

   logic                     clock;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic [CMD_W-1:0]         req_command = '0;
   logic [POS_W-1:0]         req_position = '0;
   logic signed [CARD_W-1:0] req_card_no = '0;
   logic [63:0]              req_name_part0 = '0;
   logic [63:0]              req_name_part1 = '0;
   logic [23:0]              req_name_part2 = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic                     rsp_ok;
   logic [POS_W-1:0]         rsp_found_position;
   logic signed [CARD_W-1:0] rsp_record_card;
   logic [63:0]              rsp_record_name0;
   logic [63:0]              rsp_record_name1;
   logic [23:0]              rsp_record_name2;
   logic [POS_W-1:0]         rsp_entry_count;

   rec_type  held_list[$];
   rsp_type  pending_results[$];
   name_type name_pool[POOL_SIZE];
   name_type short_name;
   int       mismatch_count = 0;
   int       send_idle_pct = 0;
   int       stall_pct = 0;
   bit       growing = 1'b1;

   positional_record_list_top #(
      .CAPACITY(LIST_DEPTH)
   ) u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_command        (req_command),
      .req_position       (req_position),
      .req_card_no        (req_card_no),
      .req_name_part0     (req_name_part0),
      .req_name_part1     (req_name_part1),
      .req_name_part2     (req_name_part2),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_ok             (rsp_ok),
      .rsp_found_position (rsp_found_position),
      .rsp_record_card    (rsp_record_card),
      .rsp_record_name0   (rsp_record_name0),
      .rsp_record_name1   (rsp_record_name1),
      .rsp_record_name2   (rsp_record_name2),
      .rsp_entry_count    (rsp_entry_count)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // ---- name helpers ----

   // zero everything past the terminating zero byte
   function automatic name_type clean_name(input name_type raw);
      name_type res;
      bit       ended;
      res   = raw;
      ended = 1'b0;
      for (int k = 0; k < NAME_CHARS; k++) begin
         if (ended) begin
            res[8*k +: 8] = 8'd0;
         end else if (raw[8*k +: 8] == 8'd0) begin
            ended = 1'b1;
         end
      end
      return res;
   endfunction

   // fill the bytes past the terminator with junk; the name itself is unchanged
   function automatic name_type roughen(input name_type n);
      name_type res;
      bit       ended;
      res   = n;
      ended = 1'b0;
      for (int k = 0; k < NAME_CHARS; k++) begin
         if (ended) begin
            res[8*k +: 8] = $urandom_range(0, 255);
         end else if (n[8*k +: 8] == 8'd0) begin
            ended = 1'b1;
         end
      end
      return res;
   endfunction

   function automatic name_type make_name(input int len);
      name_type n;
      n = '0;
      for (int k = 0; k < len; k++) begin
         n[8*k +: 8] = $urandom_range(1, 255);
      end
      return n;
   endfunction

   // ---- shadow list ----

   task automatic apply_list_command(input logic [CMD_W-1:0] cmd,
                                     input logic [POS_W-1:0] pos,
                                     input logic [CARD_W-1:0] card,
                                     input name_type raw);
      rsp_type  want;
      rec_type  entry;
      name_type key;
      int       cnt;
      int       p;
      want  = '0;
      key   = clean_name(raw);
      cnt   = held_list.size();
      p     = pos;
      case (cmd)
         CMD_INSERT: begin
            if (p >= 1 && p <= cnt + 1 && cnt < LIST_DEPTH) begin
               entry.card = card;
               entry.name = key;
               held_list.insert(p - 1, entry);
               want.ok = 1'b1;
            end
         end
         CMD_DELETE: begin
            if (p >= 1 && p <= cnt) begin
               held_list.delete(p - 1);
               want.ok = 1'b1;
            end
         end
         CMD_READ: begin
            if (p >= 1 && p <= cnt) begin
               want.ok       = 1'b1;
               want.position = p;
               want.rec      = held_list[p-1];
            end
         end
         CMD_SEARCH: begin
            for (int k = 0; k < cnt; k++) begin
               if (held_list[k].name == key) begin
                  want.ok       = 1'b1;
                  want.position = k + 1;
                  want.rec      = held_list[k];
                  break;
               end
            end
         end
         CMD_SERVE: begin
            if (cnt > 0) begin
               void'(held_list.pop_front());
               want.ok = 1'b1;
            end
         end
         default: begin
         end
      endcase
      want.count = held_list.size();
      pending_results.push_back(want);
   endtask

   // ---- drive and check ----

   task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] pos,
                            input logic [CARD_W-1:0] card, input name_type name);
      while ($urandom_range(99) < send_idle_pct) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid      <= 1'b1;
      req_command    <= cmd;
      req_position   <= pos;
      req_card_no    <= card;
      req_name_part0 <= name[63:0];
      req_name_part1 <= name[127:64];
      req_name_part2 <= name[151:128];
      @(posedge clock);
      while (req_stall) @(posedge clock);
      apply_list_command(cmd, pos, card, name);
   endtask

   task automatic wait_all_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic report_mismatch(input string what, input logic [NAME_W-1:0] got,
                                  input logic [NAME_W-1:0] want);
      $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
      mismatch_count++;
   endtask

   always @(posedge clock) begin : result_check
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected result, count", rsp_entry_count, '0);
         end else begin
            want = pending_results.pop_front();
            if (rsp_ok !== want.ok)
               report_mismatch("ok", rsp_ok, want.ok);
            if (rsp_found_position !== want.position)
               report_mismatch("found_position", rsp_found_position, want.position);
            if (rsp_record_card !== want.rec.card)
               report_mismatch("record_card", $unsigned(rsp_record_card), want.rec.card);
            if (rsp_record_name0 !== want.rec.name[63:0])
               report_mismatch("record_name0", rsp_record_name0, want.rec.name[63:0]);
            if (rsp_record_name1 !== want.rec.name[127:64])
               report_mismatch("record_name1", rsp_record_name1, want.rec.name[127:64]);
            if (rsp_record_name2 !== want.rec.name[151:128])
               report_mismatch("record_name2", rsp_record_name2, want.rec.name[151:128]);
            if (rsp_entry_count !== want.count)
               report_mismatch("entry_count", rsp_entry_count, want.count);
         end
      end
   end

   // ---- tests ----

   task automatic test_empty_list();
      send_item(CMD_READ, 8'd1, $urandom(), make_name(4));
      send_item(CMD_DELETE, 8'd1, $urandom(), make_name(4));
      send_item(CMD_SERVE, 8'd0, $urandom(), '0);
      send_item(CMD_SEARCH, 8'd0, $urandom(), '0);
      send_item(CMD_INSERT, 8'd0, $urandom(), make_name(6));
      // only position 1 is legal on an empty list
      send_item(CMD_INSERT, 8'd2, $urandom(), make_name(6));
   endtask

   task automatic test_unknown_commands();
      for (int c = CMD_UNUSED_FIRST; c <= CMD_UNUSED_LAST; c++) begin
         send_item(c, $urandom_range(0, 255), $urandom(), roughen(make_name(8)));
      end
   endtask

   task automatic test_insert_edges();
      short_name = make_name(5);
      send_item(CMD_INSERT, 8'd1, 32'h7fff_ffff, '1);
      send_item(CMD_INSERT, 8'd2, 32'h8000_0000, '0);
      send_item(CMD_INSERT, 8'd1, 32'h0000_0000, roughen(short_name));
      send_item(CMD_INSERT, 8'd4, 32'hffff_ffff, make_name(NAME_CHARS));
      send_item(CMD_INSERT, 8'd255, $urandom(), make_name(3));
      send_item(CMD_INSERT, 8'd6, $urandom(), make_name(3));
   endtask

   task automatic test_read_search();
      send_item(CMD_READ, 8'd1, $urandom(), '0);
      send_item(CMD_READ, 8'd4, $urandom(), '0);
      send_item(CMD_READ, 8'd5, $urandom(), '0);
      send_item(CMD_READ, 8'd0, $urandom(), '0);
      // key with junk past its terminator must still hit
      send_item(CMD_SEARCH, 8'd0, $urandom(), roughen(short_name));
      send_item(CMD_SEARCH, 8'd0, $urandom(), roughen('0));
      send_item(CMD_SEARCH, 8'd0, $urandom(), '1);
      send_item(CMD_SEARCH, 8'd0, $urandom(), make_name(NAME_CHARS));
   endtask

   task automatic test_delete_serve();
      send_item(CMD_DELETE, 8'd0, $urandom(), '0);
      send_item(CMD_DELETE, 8'd5, $urandom(), '0);
      send_item(CMD_DELETE, 8'd2, $urandom(), '0);
      send_item(CMD_SERVE, 8'd0, $urandom(), '0);
   endtask

   // fill-and-drain traffic; the list swings between empty and full
   task automatic test_random_traffic(input int num_items, input int idle, input int stall);
      int                r;
      int                cnt;
      logic [CMD_W-1:0]  cmd;
      logic [POS_W-1:0]  pos;
      name_type          name;
      send_idle_pct = idle;
      stall_pct     = stall;
      for (int i = 0; i < num_items; i++) begin
         cnt = held_list.size();
         if (cnt == LIST_DEPTH && $urandom_range(3) == 0) growing = 1'b0;
         if (cnt == 0 && $urandom_range(1) == 0) growing = 1'b1;
         r = $urandom_range(99);
         if (growing) begin
            if (r < 48)      cmd = CMD_INSERT;
            else if (r < 58) cmd = CMD_DELETE;
            else if (r < 72) cmd = CMD_READ;
            else if (r < 86) cmd = CMD_SEARCH;
            else if (r < 96) cmd = CMD_SERVE;
            else             cmd = $urandom_range(CMD_UNUSED_FIRST, CMD_UNUSED_LAST);
         end else begin
            if (r < 12)      cmd = CMD_INSERT;
            else if (r < 42) cmd = CMD_DELETE;
            else if (r < 57) cmd = CMD_READ;
            else if (r < 72) cmd = CMD_SEARCH;
            else if (r < 94) cmd = CMD_SERVE;
            else             cmd = $urandom_range(CMD_UNUSED_FIRST, CMD_UNUSED_LAST);
         end

         if ($urandom_range(99) < 15) begin
            pos = $urandom_range(0, 255);
         end else if (cmd == CMD_INSERT) begin
            pos = $urandom_range(1, cnt + 1);
         end else if (cnt > 0) begin
            pos = $urandom_range(1, cnt);
         end else begin
            pos = $urandom_range(0, 255);
         end

         r = $urandom_range(99);
         if (cmd == CMD_SEARCH && cnt > 0 && r < 50) begin
            name = held_list[$urandom_range(0, cnt - 1)].name;
         end else if ((cmd == CMD_SEARCH || cmd == CMD_INSERT) && r < 80) begin
            name = name_pool[$urandom_range(0, POOL_SIZE - 1)];
         end else begin
            name = make_name($urandom_range(0, NAME_CHARS));
         end
         send_item(cmd, pos, $urandom(), roughen(name));
      end
      wait_all_results();
   endtask

   initial begin
      for (int k = 0; k < POOL_SIZE; k++) begin
         name_pool[k] = make_name($urandom_range(0, NAME_CHARS));
      end
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_empty_list();
      test_unknown_commands();
      test_insert_edges();
      test_read_search();
      test_delete_serve();
      wait_all_results();

      test_random_traffic(425, 0, 0);
      test_random_traffic(425, 82, 0);
      test_random_traffic(425, 0, 82);
      test_random_traffic(425, 30, 30);

      wait_all_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (pending_results.size() != 0)
         report_mismatch("results never arrived", pending_results.size(), '0);
      if (mismatch_count == 0) begin
         $display("** positional_record_list_top: PASSED **");
      end else begin
         $display("** positional_record_list_top: FAILED **");
      end
      $finish;
   end

   initial begin
      #4_000_000;
      $display("** positional_record_list_top: FAILED **");
      $finish;
   end

endmodule

>>> positional_record_list_top.f
+incdir+src
src/prl_pkg.sv
src/prl_ram.sv
src/prl_engine.sv
src/positional_record_list_top.sv
tb/sv/positional_record_list_top_tb.sv
